[rtl/edb_pkg.sv]
`timescale 1ns / 1ps

package edb_pkg;

  // field widths
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned IMG_W_W    = 13;
  localparam int unsigned IMG_H_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // error terms kept in state, and the wider working width for one pixel
  localparam int unsigned ERR_W = 11;
  localparam int unsigned ACC_W = 18;

  localparam int unsigned DEFAULT_MAX_WIDTH = 4096;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(4096);
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(1);

  localparam logic signed [ACC_W-1:0] WHITE_THRESH = ACC_W'(127);
  localparam logic signed [ACC_W-1:0] WHITE_LEVEL  = ACC_W'(255);
  localparam logic signed [ACC_W-1:0] SHARE_RIGHT  = ACC_W'(7);
  localparam logic signed [ACC_W-1:0] SHARE_DLEFT  = ACC_W'(3);
  localparam logic signed [ACC_W-1:0] SHARE_DOWN   = ACC_W'(5);
  localparam int unsigned SHARE_SHIFT = 4;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (ERR_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (ERR_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT
  } cfg_reg_e;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic err_t sat_err(input acc_t v);
    err_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[ERR_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  function automatic acc_t sext_err(input err_t v);
    return {{(ACC_W - ERR_W){v[ERR_W-1]}}, v};
  endfunction

endpackage

[rtl/edb_stream_if.sv]
`timescale 1ns / 1ps

interface edb_gray_if;
  import edb_pkg::*;

  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_in;

  modport source (output valid, output gray_in, input ready);
  modport sink (input valid, input gray_in, output ready);
endinterface

interface edb_bit_if;
  logic valid;
  logic ready;
  logic white_out;

  modport source (output valid, output white_out, input ready);
  modport sink (input valid, input white_out, output ready);
endinterface

[rtl/edb_ram.sv]
`timescale 1ns / 1ps

module edb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/error_diffusion_bitonal_unit.sv]
`timescale 1ns / 1ps

// Floyd-Steinberg dither from 8-bit gray to one bit per pixel, raster order.
// One pixel is taken every clock while input ready is high; its bit is
// registered into the output register, or into the skid stage, and the skid
// stage keeps input ready for one more beat while the output is stalled. The
// per-pixel rate is set by the right-neighbor error loop (add, compare, scale).
// The next-row errors live in a MAX_WIDTH-deep RAM with a registered read
// port, addressed one column ahead; a bypass register and a last-column
// holding register cover the entries written too late for that read. The
// held last-column entry is copied into the RAM on the next cycle without a
// pixel write, which is at the latest the first pixel of the following row.
// image_width and image_height may only be written while no pixel is in
// flight; row and column counters are not cleared by such a write.

module error_diffusion_bitonal_unit #(
  parameter int unsigned MAX_WIDTH = edb_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [edb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [edb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  edb_gray_if.sink                        gray_i,
  edb_bit_if.source                       white_o
);
  import edb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int unsigned HW = IMG_H_W + 1;

  // configuration
  logic [IMG_W_W-1:0] image_width_q;
  logic [IMG_H_W-1:0] image_height_q;

  // scan state
  logic [CW-1:0]      column_count_q, column_count_d;
  logic [IMG_H_W-1:0] row_count_q, row_count_d;
  err_t               right_carry_q, right_carry_d;
  err_t               pend_dl_q, pend_dl_d;
  err_t               pend_dn_q, pend_dn_d;

  // row store side paths
  logic               tail_vld_q;
  logic               tail_dirty_q;
  logic [CW-1:0]      tail_col_q;
  err_t               tail_err_q;
  logic               fwd_vld_q;
  err_t               fwd_err_q;

  // output register and skid stage
  logic               out_vld_q, out_bit_q;
  logic               skid_vld_q, skid_bit_q;

  logic               accept;
  logic [EW-1:0]      w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic               last_col, last_row, first_col;
  logic               white;
  acc_t               stored, v, e;
  acc_t               share_r, share_dl, share_dn, share_dr;
  err_t               ram_rdata, wr_err, pd;
  logic               px_we;
  logic               ram_we;
  logic [CW-1:0]      ram_waddr;
  err_t               ram_wdata;

  assign gray_i.ready = !skid_vld_q;
  assign accept       = gray_i.valid && gray_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMG_W_RESET;
      image_height_q <= IMG_H_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = EW'(image_width_q);
    if (image_width_q == '0) begin
      w_eff = EW'(1);
    end else if (w_eff > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end
    h_eff = (image_height_q == '0) ? IMG_H_W'(1) : image_height_q;
  end

  assign last_col  = (EW'(column_count_q) + EW'(1)) >= w_eff;
  assign last_row  = (HW'(row_count_q) + HW'(1)) >= HW'(h_eff);
  assign first_col = (column_count_q == '0);

  // next-row error for this column: zero on row 0, else holding register, then bypass, then RAM
  always_comb begin
    if (row_count_q == '0) begin
      stored = '0;
    end else if (tail_vld_q && (tail_col_q == column_count_q)) begin
      stored = sext_err(tail_err_q);
    end else if (fwd_vld_q) begin
      stored = sext_err(fwd_err_q);
    end else begin
      stored = sext_err(ram_rdata);
    end
  end

  always_comb begin
    v     = acc_t'({1'b0, gray_i.gray_in}) + sext_err(right_carry_q) + stored;
    white = v > WHITE_THRESH;
    e     = white ? (v - WHITE_LEVEL) : v;

    share_r  = '0;
    share_dl = '0;
    share_dn = '0;
    share_dr = '0;
    if (!last_col) begin
      share_r = (e * SHARE_RIGHT) >>> SHARE_SHIFT;
    end
    if (!last_row) begin
      share_dn = (e * SHARE_DOWN) >>> SHARE_SHIFT;
      if (!first_col) begin
        share_dl = (e * SHARE_DLEFT) >>> SHARE_SHIFT;
      end
      if (!last_col) begin
        share_dr = e >>> SHARE_SHIFT;
      end
    end

    wr_err = sat_err(sext_err(pend_dn_q) + share_dl);
    pd     = sat_err(sext_err(pend_dl_q) + share_dn);
  end

  always_comb begin
    column_count_d = column_count_q;
    row_count_d    = row_count_q;
    right_carry_d  = right_carry_q;
    pend_dl_d      = pend_dl_q;
    pend_dn_d      = pend_dn_q;
    if (accept) begin
      if (last_col) begin
        column_count_d = '0;
        row_count_d    = last_row ? '0 : row_count_q + IMG_H_W'(1);
        right_carry_d  = '0;
        pend_dl_d      = '0;
        pend_dn_d      = '0;
      end else begin
        column_count_d = column_count_q + CW'(1);
        right_carry_d  = sat_err(share_r);
        pend_dl_d      = sat_err(share_dr);
        pend_dn_d      = pd;
      end
    end
  end

  // pixel writes own the port; the held last-column entry goes in when it is free
  assign px_we     = accept && !first_col;
  assign ram_we    = px_we || tail_dirty_q;
  assign ram_waddr = px_we ? (column_count_q - CW'(1)) : tail_col_q;
  assign ram_wdata = px_we ? wr_err : tail_err_q;

  edb_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (column_count_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      row_count_q    <= '0;
      right_carry_q  <= '0;
      pend_dl_q      <= '0;
      pend_dn_q      <= '0;
      tail_vld_q     <= 1'b0;
      tail_dirty_q   <= 1'b0;
      fwd_vld_q      <= 1'b0;
    end else begin
      column_count_q <= column_count_d;
      row_count_q    <= row_count_d;
      right_carry_q  <= right_carry_d;
      pend_dl_q      <= pend_dl_d;
      pend_dn_q      <= pend_dn_d;
      // the last column's entry would need a second write port; hold it aside
      if (accept && last_col) begin
        tail_vld_q <= 1'b1;
      end else if (px_we && (ram_waddr == tail_col_q)) begin
        tail_vld_q <= 1'b0;
      end
      if (accept && last_col) begin
        tail_dirty_q <= 1'b1;
      end else if (!px_we) begin
        tail_dirty_q <= 1'b0;
      end
      fwd_vld_q <= ram_we && (ram_waddr == column_count_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_col) begin
      tail_col_q <= column_count_q;
      tail_err_q <= pd;
    end
    fwd_err_q <= ram_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (white_o.ready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_vld_q || white_o.ready) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (white_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (white_o.ready) begin
        out_bit_q <= skid_bit_q;
      end
    end else if (accept) begin
      if (!out_vld_q || white_o.ready) begin
        out_bit_q <= white;
      end else begin
        skid_bit_q <= white;
      end
    end
  end

  assign white_o.valid     = out_vld_q;
  assign white_o.white_out = out_bit_q;

endmodule
